[sv/ufcsd_pkg.sv]
// ----------------------------------------------------------------------------
// ufcsd_pkg
// Constants and field layout shared by the packet deframer and its checker.
// ----------------------------------------------------------------------------
package ufcsd_pkg;

    localparam int          COUNT_W   = 9;

    localparam logic [7:0]  SOP_BYTE  = 8'hAA;
    localparam logic [7:0]  CRC_POLY  = 8'h29;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
    localparam logic [COUNT_W-1:0] LEN_SHORT = 9'd4;
    localparam logic [COUNT_W-1:0] LEN_EXTRA = 9'd5;
    localparam logic [7:0]  CTRL_TYPE_MAX = 8'd15;
    localparam logic [7:0]  TEST_TYPE     = 8'd255;

    // Values of tuser on the result channel.
    localparam logic EVENT_SOP  = 1'b0;
    localparam logic EVENT_DONE = 1'b1;

    // Message classes.
    localparam logic [2:0] CLASS_CTRL_KNOWN = 3'd0;
    localparam logic [2:0] CLASS_CTRL_RSVD  = 3'd1;
    localparam logic [2:0] CLASS_DATA_KNOWN = 3'd2;
    localparam logic [2:0] CLASS_TEST_REQ   = 3'd3;
    localparam logic [2:0] CLASS_DATA_UNKN  = 3'd4;

    // Result payload, lowest field in the lowest bits of tdata.
    typedef struct packed {
        logic       crc_ok;
        logic [7:0] crc_computed;
        logic [7:0] crc_received;
        logic [2:0] msg_class;
        logic [7:0] data_length;
        logic [7:0] msg_type;
        logic [4:0] revision;
        logic [2:0] power_role;
        logic [3:0] msg_id;
    } result_t;

endpackage

[sv/ufcs_packet_deframer_top.sv]
// ----------------------------------------------------------------------------
// ufcs_packet_deframer_top
// Splits a received byte stream into packets, decodes the header and checks
// the CRC-8 of each packet.
// ----------------------------------------------------------------------------
// Latency: two register stages (input register, then result register); a
// result is captured in the result register after its byte leaves the input register.
// Throughput: one byte per cycle unless a result waits on a stalled output;
// CRC-8 update and header capture finish in the stage between the registers.
// Reset: synchronous, active low; clears the byte counter, packet length,
// running CRC, header bytes and both valid flags.
module ufcs_packet_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // msg_id[3:0], power_role[6:4], revision[11:7],
                                   // msg_type[19:12], data_length[27:20],
                                   // msg_class[30:28], crc_received[38:31],
                                   // crc_computed[46:39], crc_ok[47]
    output logic        m_tuser    // event_kind[0]
);

    localparam int CW = ufcsd_pkg::COUNT_W;

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        len_reg, len_next;
    logic [7:0]           crc_reg, crc_next;
    logic [7:0]           hdr_reg [4];
    logic [7:0]           hdr_next [4];
    logic                 out_valid_reg;
    logic                 out_kind_reg;
    ufcsd_pkg::result_t   out_data_reg, res_data;

    logic is_sop, is_last, has_result, out_free, proc_go;
    logic [7:0] data_len;
    logic [2:0] msg_class;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ ufcsd_pkg::CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    assign out_free   = !out_valid_reg || m_tready;
    assign has_result = is_sop || is_last;
    assign proc_go    = in_valid_reg && (out_free || !has_result);
    assign s_tready   = !in_valid_reg || proc_go;

    always_comb begin
        is_sop     = (in_byte_reg == ufcsd_pkg::SOP_BYTE);
        hdr_next   = hdr_reg;
        len_next   = len_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        is_last    = 1'b0;
        if (is_sop) begin
            count_next = '0;
            len_next   = '0;
            crc_next   = '0;
        end else begin
            if (count_reg < CW'(4)) begin
                hdr_next[count_reg[1:0]] = in_byte_reg;
            end
            // The fourth byte fixes the length; header byte 1 is already stored.
            if (count_reg == CW'(3)) begin
                len_next = hdr_reg[1][0] ? ({1'b0, in_byte_reg} + ufcsd_pkg::LEN_EXTRA)
                                         : ufcsd_pkg::LEN_SHORT;
            end
            is_last = (len_next != '0) &&
                      (({1'b0, count_reg} + (CW+1)'(1)) == {1'b0, len_next});
            if (count_reg < ufcsd_pkg::COUNT_MAX) begin
                count_next = count_reg + CW'(1);
            end
            if (!is_last) begin
                crc_next = crc8_byte(crc_reg, in_byte_reg);
            end
        end
    end

    always_comb begin
        data_len = (hdr_next[1][2:0] == 3'd1) ? hdr_next[3] : 8'd0;
        if (data_len == 8'd0) begin
            msg_class = (hdr_next[2] > ufcsd_pkg::CTRL_TYPE_MAX) ?
                        ufcsd_pkg::CLASS_CTRL_RSVD : ufcsd_pkg::CLASS_CTRL_KNOWN;
        end else if (hdr_next[2] == ufcsd_pkg::TEST_TYPE) begin
            msg_class = ufcsd_pkg::CLASS_TEST_REQ;
        end else if (hdr_next[2] inside {[8'd1:8'd11]}) begin
            msg_class = ufcsd_pkg::CLASS_DATA_KNOWN;
        end else begin
            msg_class = ufcsd_pkg::CLASS_DATA_UNKN;
        end

        res_data = '0;
        if (!is_sop) begin
            res_data.msg_id       = hdr_next[0][4:1];
            res_data.power_role   = hdr_next[0][7:5];
            res_data.revision     = hdr_next[1][7:3];
            res_data.msg_type     = hdr_next[2];
            res_data.data_length  = data_len;
            res_data.msg_class    = msg_class;
            res_data.crc_received = in_byte_reg;
            res_data.crc_computed = crc_reg;
            res_data.crc_ok       = (in_byte_reg == crc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            len_reg       <= '0;
            crc_reg       <= '0;
            for (int i = 0; i < 4; i++) begin
                hdr_reg[i] <= '0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_tdata;
            end else if (proc_go) begin
                in_valid_reg <= 1'b0;
            end

            if (proc_go) begin
                count_reg <= count_next;
                len_reg   <= len_next;
                crc_reg   <= crc_next;
                hdr_reg   <= hdr_next;
            end

            if (proc_go && has_result) begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= is_sop ? ufcsd_pkg::EVENT_SOP : ufcsd_pkg::EVENT_DONE;
                out_data_reg  <= res_data;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

[sv/ufcsd_checker.sv]
// ----------------------------------------------------------------------------
// ufcsd_checker
// Port-level checks on the result channel of the packet deframer.
// ----------------------------------------------------------------------------
module ufcsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    ufcsd_pkg::result_t res;
    assign res = m_tdata;

    // A stalled result must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Start-of-packet results carry an all-zero payload.
    a_sop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ufcsd_pkg::EVENT_SOP) |-> (m_tdata == '0))
        else $error("start-of-packet result with nonzero payload");

    // The check flag agrees with the two CRC fields.
    a_crc_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ufcsd_pkg::EVENT_DONE) |->
            (res.crc_ok == (res.crc_received == res.crc_computed)))
        else $error("crc_ok disagrees with crc fields");

    // Packets without a data length are always control class.
    a_ctrl_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ufcsd_pkg::EVENT_DONE) && (res.data_length == 8'd0) |->
            (res.msg_class == ufcsd_pkg::CLASS_CTRL_KNOWN) ||
            (res.msg_class == ufcsd_pkg::CLASS_CTRL_RSVD))
        else $error("control packet with a data class");

    // Nothing is shown in the cycle after reset.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ufcs_packet_deframer_top ufcsd_checker u_ufcsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the packet deframer. A built-in predictor mirrors the
// counter, length, CRC-8 and header state. Each accepted item is predicted, and
// every result on the master channel is compared field by field with the oldest
// pending event. Traffic runs with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD   = 10;
    localparam int          TIMEOUT_NS    = 10_000_000;
    localparam int          RANDOM_ITEMS  = 320;
    localparam logic [7:0]  DATA_TYPE_MAX = 8'd11;

    typedef struct packed {
        logic               kind;
        ufcsd_pkg::result_t fields;
    } deframe_event_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // rx_byte[7:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;            // msg_id[3:0], power_role[6:4], revision[11:7],
                                     // msg_type[19:12], data_length[27:20],
                                     // msg_class[30:28], crc_received[38:31],
                                     // crc_computed[46:39], crc_ok[47]
    logic        m_tuser;            // event_kind[0]

    // Predictor state, zero from the start just like the block after reset.
    logic [ufcsd_pkg::COUNT_W-1:0] byte_count  = '0;
    logic [ufcsd_pkg::COUNT_W-1:0] frame_len   = '0;
    logic [7:0]         frame_crc   = 8'h00;
    logic [7:0]         hdr_bytes [4] = '{default: 8'h00};

    deframe_event_t pending_events [$];

    int          mismatch_count = 0;
    int          bytes_sent     = 0;
    int          burst_left     = 0;
    bit          gaps_on        = 1'b0;
    bit          stall_on       = 1'b0;
    logic [15:0] stall_pat      = 16'hFFFF;
    logic [3:0]  stall_pos      = 4'd0;

    ufcs_packet_deframer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ ufcsd_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] non_sop_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == ufcsd_pkg::SOP_BYTE);
        return b;
    endfunction

    // Advances the predictor by one accepted byte and queues any event it causes.
    task automatic predict_deframe(input logic [7:0] b);
        deframe_event_t ev;
        logic [ufcsd_pkg::COUNT_W-1:0] idx;
        logic [7:0] dlen;
        logic [7:0] mtype;
        bit is_last;
        ev = '0;
        if (b == ufcsd_pkg::SOP_BYTE) begin
            byte_count = '0;
            frame_len  = '0;
            frame_crc  = 8'h00;
            ev.kind    = ufcsd_pkg::EVENT_SOP;
            pending_events.push_back(ev);
        end else begin
            idx = byte_count;
            if (idx < 4)
                hdr_bytes[idx[1:0]] = b;
            if (idx == 3)
                frame_len = hdr_bytes[1][0] ?
                            ufcsd_pkg::COUNT_W'(hdr_bytes[3]) + ufcsd_pkg::LEN_EXTRA
                          : ufcsd_pkg::LEN_SHORT;
            is_last = (frame_len != 0) && (int'(idx) + 1 == int'(frame_len));
            if (byte_count < ufcsd_pkg::COUNT_MAX)
                byte_count = byte_count + ufcsd_pkg::COUNT_W'(1);
            if (!is_last) begin
                frame_crc = crc8_step(frame_crc, b);
            end else begin
                mtype = hdr_bytes[2];
                dlen  = (hdr_bytes[1][2:0] == 3'd1) ? hdr_bytes[3] : 8'h00;
                ev.kind                = ufcsd_pkg::EVENT_DONE;
                ev.fields.msg_id       = hdr_bytes[0][4:1];
                ev.fields.power_role   = hdr_bytes[0][7:5];
                ev.fields.revision     = hdr_bytes[1][7:3];
                ev.fields.msg_type     = mtype;
                ev.fields.data_length  = dlen;
                if (dlen == 8'h00)
                    ev.fields.msg_class = (mtype > ufcsd_pkg::CTRL_TYPE_MAX) ?
                                          ufcsd_pkg::CLASS_CTRL_RSVD
                                        : ufcsd_pkg::CLASS_CTRL_KNOWN;
                else if (mtype == ufcsd_pkg::TEST_TYPE)
                    ev.fields.msg_class = ufcsd_pkg::CLASS_TEST_REQ;
                else if (mtype >= 8'd1 && mtype <= DATA_TYPE_MAX)
                    ev.fields.msg_class = ufcsd_pkg::CLASS_DATA_KNOWN;
                else
                    ev.fields.msg_class = ufcsd_pkg::CLASS_DATA_UNKN;
                ev.fields.crc_received = b;
                ev.fields.crc_computed = frame_crc;
                ev.fields.crc_ok       = (b == frame_crc);
                pending_events.push_back(ev);
            end
        end
    endtask

    // Offers one item; the sender pauses between bursts when gaps are enabled.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            if (gaps_on) begin
                gap = $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        predict_deframe(b);
        burst_left--;
        bytes_sent++;
    endtask

    // Sends SOP and one frame. A long frame carries h3 payload bytes. When cut_at
    // points inside the frame, that byte is replaced by a start mark.
    task automatic send_packet(input logic [7:0] h0, input logic [7:0] h1,
                               input logic [7:0] h2, input logic [7:0] h3,
                               input bit crc_good, input int cut_at);
        logic [7:0] frame [$];
        logic [7:0] crc;
        frame = {h0, h1, h2};
        if (h1[0]) begin
            frame.push_back(h3);
            repeat (int'(h3)) frame.push_back(non_sop_byte());
        end
        crc = 8'h00;
        foreach (frame[i]) crc = crc8_step(crc, frame[i]);
        frame.push_back(crc_good ? crc : 8'($urandom));
        if (cut_at >= 0 && cut_at < frame.size())
            frame[cut_at] = ufcsd_pkg::SOP_BYTE;
        send_byte(ufcsd_pkg::SOP_BYTE);
        foreach (frame[i]) send_byte(frame[i]);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!stall_on) begin
            m_tready <= 1'b1;
        end else begin
            m_tready  <= stall_pat[stall_pos];
            stall_pos <= stall_pos + 1'b1;
            if (stall_pos == 4'd15)
                stall_pat <= 16'($urandom) | 16'h0001;
        end
    end

    always @(posedge aclk) begin
        deframe_event_t want;
        ufcsd_pkg::result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = ufcsd_pkg::result_t'(m_tdata);
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result, expected none actual tuser %0h tdata %012h",
                         $realtime, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind",   8'(want.kind),                8'(m_tuser));
                check_field("msg_id",       8'(want.fields.msg_id),       8'(got.msg_id));
                check_field("power_role",   8'(want.fields.power_role),   8'(got.power_role));
                check_field("revision",     8'(want.fields.revision),     8'(got.revision));
                check_field("msg_type",     want.fields.msg_type,         got.msg_type);
                check_field("data_length",  want.fields.data_length,      got.data_length);
                check_field("msg_class",    8'(want.fields.msg_class),    8'(got.msg_class));
                check_field("crc_received", want.fields.crc_received,     got.crc_received);
                check_field("crc_computed", want.fields.crc_computed,     got.crc_computed);
                check_field("crc_ok",       8'(want.fields.crc_ok),       8'(got.crc_ok));
            end
        end
    end

    // Bytes before any start mark are counted but cannot complete a frame yet.
    task automatic test_preamble_bytes();
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
    endtask

    task automatic test_short_packets();
        send_packet(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, -1);
        send_packet(8'hFF, 8'hFE, 8'h10, 8'h00, 1'b0, -1);
        send_packet(8'h3C, 8'h08, 8'h0F, 8'h00, 1'b1, -1);
    endtask

    // Long frames, including a length bit that disagrees with the data length field.
    task automatic test_long_packets();
        send_packet(8'h22, 8'h09, ufcsd_pkg::TEST_TYPE, 8'h01, 1'b1, -1);
        send_packet(8'h44, 8'h01, 8'h05,     8'h00, 1'b1, -1);
        send_packet(8'h46, 8'h0B, 8'h03,     8'h02, 1'b1, -1);
        send_packet(8'h48, 8'h01, 8'h0C,     8'h01, 1'b0, -1);
        send_packet(8'h4A, 8'h01, 8'h00,     8'h01, 1'b1, -1);
    endtask

    // A start mark inside the header, inside the payload and in the CRC position.
    task automatic test_restart();
        send_packet(8'h10, 8'h01, 8'h02, 8'h02, 1'b1, 2);
        send_packet(8'h10, 8'h01, 8'h02, 8'h02, 1'b1, 5);
        send_packet(8'h10, 8'h00, 8'h02, 8'h00, 1'b1, 3);
    endtask

    task automatic test_trailing_bytes();
        send_packet(8'h20, 8'h10, 8'h01, 8'h00, 1'b1, -1);
        repeat (6) send_byte(non_sop_byte());
    endtask

    task automatic test_max_length();
        send_packet(8'h5A, 8'hF9, ufcsd_pkg::TEST_TYPE, 8'hFF, 1'b1, -1);
    endtask

    // Runs the byte counter into its ceiling, then checks that framing recovers.
    task automatic test_counter_saturation();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        send_packet(8'h30, 8'h00, 8'h01, 8'h00, 1'b1, -1);
        repeat (526) send_byte(non_sop_byte());
        send_packet(8'h32, 8'h00, 8'h02, 8'h00, 1'b1, -1);
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int pick;
        int len_pick;
        logic [7:0] h0, h1, h2, h3;
        stop_at = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 15) == 0) begin
                gaps_on  = $urandom_range(0, 2) != 0;
                stall_on = $urandom_range(0, 2) != 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 90) begin
                h0 = non_sop_byte();
                len_pick = $urandom_range(0, 2);
                do begin
                    h1 = 8'($urandom);
                    if (len_pick == 0)
                        h1[0] = 1'b0;
                    else if (len_pick == 1)
                        h1[2:0] = 3'd1;
                    else
                        h1[0] = 1'b1;
                end while (h1 == ufcsd_pkg::SOP_BYTE);
                case ($urandom_range(0, 3))
                    0: h2 = 8'($urandom_range(0, 15));
                    1: h2 = 8'($urandom_range(1, 11));
                    2: h2 = ufcsd_pkg::TEST_TYPE;
                    default: h2 = non_sop_byte();
                endcase
                h3 = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(7, 60))
                                                  : 8'($urandom_range(0, 6));
                send_packet(h0, h1, h2, h3, $urandom_range(0, 99) < 85,
                            (pick < 8) ? int'($urandom_range(0, 8)) : -1);
            end else begin
                repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_preamble_bytes();
        test_short_packets();
        test_long_packets();
        test_restart();
        test_trailing_bytes();
        test_max_length();
        test_counter_saturation();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("testbench: errors");
        $finish;
    end

endmodule

[sim.f]
sv/ufcsd_pkg.sv
sv/ufcs_packet_deframer_top.sv
sv/ufcsd_checker.sv
dv/testbench.sv
